/* rtl/fcwp_pkg.sv */
// Shared types, constants and color tables for the false-color weather pixel pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package fcwp_pkg;

    typedef enum logic [1:0] {
        MODE_FLUX  = 2'd0,
        MODE_WIND  = 2'd1,
        MODE_BANDS = 2'd2,
        MODE_DIFF  = 2'd3
    } mode_t;

    localparam int RATE_DIV    = 13890;    // 5 * 2778, smoothed sum per mm/hr
    localparam int DIFF_FULL   = 2500200;  // 180 mm/hr in smoothed-sum units
    localparam int WIND_FULL   = 2560;     // 10 m/s in 1/256 m/s
    localparam int WIND_DEN    = 5;
    localparam int WIND_SHIFT  = 7;        // 128*m/5
    localparam int DIFF_SHIFT  = 32;       // m*2^32/DIFF_FULL
    localparam int PAINT_MIN   = 578;      // 24*S > 13890 <=> S > 578
    localparam int NUM_LIMITS  = 13;
    localparam int ROOT_STEPS  = 9;        // root result 0..256
    localparam int PW          = 60;       // power accumulator width

    typedef logic [PW-1:0] pow_t;

    typedef struct packed {
        mode_t       mode;
        logic        skip;   // edge pixel: plain gray
        logic        neg;    // sign of the overlay quantity
        logic        paint;  // band mode: rate above threshold
        logic [3:0]  band;
        logic [7:0]  gray;
        logic [7:0]  dark;
    } side_t;

    function automatic logic [21:0] band_threshold(input logic [3:0] k);
        logic [21:0] t;
        unique case (k)
            4'd0:    t = 22'(1 * RATE_DIV);
            4'd1:    t = 22'(2 * RATE_DIV);
            4'd2:    t = 22'(3 * RATE_DIV);
            4'd3:    t = 22'(4 * RATE_DIV);
            4'd4:    t = 22'(5 * RATE_DIV);
            4'd5:    t = 22'(10 * RATE_DIV);
            4'd6:    t = 22'(15 * RATE_DIV);
            4'd7:    t = 22'(20 * RATE_DIV);
            4'd8:    t = 22'(35 * RATE_DIV);
            4'd9:    t = 22'(50 * RATE_DIV);
            4'd10:   t = 22'(75 * RATE_DIV);
            4'd11:   t = 22'(100 * RATE_DIV);
            4'd12:   t = 22'(150 * RATE_DIV);
            default: t = '1;
        endcase
        return t;
    endfunction

    // {red, green, blue}
    function automatic logic [23:0] band_color(input logic [3:0] k);
        logic [23:0] c;
        unique case (k)
            4'd0:    c = {8'd0,   8'd64,  8'd64};
            4'd1:    c = {8'd0,   8'd64,  8'd0};
            4'd2:    c = {8'd0,   8'd128, 8'd0};
            4'd3:    c = {8'd0,   8'd192, 8'd0};
            4'd4:    c = {8'd128, 8'd192, 8'd0};
            4'd5:    c = {8'd192, 8'd228, 8'd0};
            4'd6:    c = {8'd228, 8'd192, 8'd0};
            4'd7:    c = {8'd255, 8'd128, 8'd0};
            4'd8:    c = {8'd192, 8'd64,  8'd0};
            4'd9:    c = {8'd128, 8'd0,   8'd0};
            4'd10:   c = {8'd192, 8'd0,   8'd0};
            4'd11:   c = {8'd255, 8'd0,   8'd255};
            4'd12:   c = {8'd128, 8'd0,   8'd192};
            4'd13:   c = {8'd240, 8'd240, 8'd240};
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [8:0] band_alpha(input logic [3:0] k);
        logic [8:0] a;
        unique case (k)
            4'd0, 4'd1: a = 9'd77;
            4'd2:       a = 9'd128;
            4'd3:       a = 9'd179;
            4'd4:       a = 9'd230;
            default:    a = 9'd256;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* rtl/fcwp_front.sv */
// Front end: gray level from flux, overlay smoothing, band search and root targets.
// Three register stages; depends on fcwp_pkg.
`default_nettype none

module fcwp_front
    import fcwp_pkg::*;
#(
    parameter int OVERLAY_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire mode_t                          mode,
    input  wire logic [15:0]                    flux_value,
    input  wire logic signed [OVERLAY_BITS-1:0] overlay_left,
    input  wire logic signed [OVERLAY_BITS-1:0] overlay_center,
    input  wire logic signed [OVERLAY_BITS-1:0] overlay_right,
    input  wire logic                           edge_pixel,
    output logic                                out_valid,
    output side_t                               out_side,
    output pow_t                                out_target,
    output logic                                out_sel4,
    output pow_t                                out_k0
);

    localparam int SW = OVERLAY_BITS + 3;
    localparam int MW = (SW > 23) ? SW : 23;

    // stage 1
    logic [15:0]          f_clamp;
    logic                 lo_next;
    logic [11:0]          span;
    logic [18:0]          x_next;
    logic signed [SW-1:0] s_next;
    logic [OVERLAY_BITS-1:0] umag;
    logic [11:0]          w_next;

    logic                 v1_reg;
    mode_t                mode1_reg;
    logic                 skip1_reg;
    logic                 lo1_reg;
    logic [18:0]          x1_reg;
    logic signed [SW-1:0] s1_reg;
    logic                 wneg1_reg;
    logic [11:0]          w1_reg;

    always_comb
    begin
        if (flux_value < 16'd1280)
        begin
            f_clamp = 16'd1280;
        end
        else if (flux_value > 16'd4800)
        begin
            f_clamp = 16'd4800;
        end
        else
        begin
            f_clamp = flux_value;
        end
        lo_next = (f_clamp < 16'd1920);
        span    = lo_next ? 12'(16'd1920 - f_clamp) : 12'(16'd4800 - f_clamp);
        x_next  = (lo_next ? 19'd114240 : 19'd367200) + 19'(span) * 19'd51;
        s_next  = SW'(overlay_left) + SW'(overlay_center) + SW'(overlay_center)
                + SW'(overlay_center) + SW'(overlay_right);
        umag    = overlay_center[OVERLAY_BITS-1] ? $unsigned(-overlay_center)
                                                 : $unsigned(overlay_center);
        w_next  = (umag > OVERLAY_BITS'(WIND_FULL)) ? 12'(WIND_FULL) : umag[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= mode;
        skip1_reg <= edge_pixel;
        lo1_reg   <= lo_next;
        x1_reg    <= x_next;
        s1_reg    <= s_next;
        wneg1_reg <= overlay_center[OVERLAY_BITS-1];
        w1_reg    <= w_next;
    end

    // stage 2: divide by 640 or 2880 via reciprocal, band search, root target
    logic [12:0]          n_div;
    logic [13:0]          recip;
    logic [26:0]          prod;
    logic [7:0]           gray_next;
    logic                 sneg;
    logic [SW-1:0]        smag;
    logic [MW-1:0]        smag_w;
    logic [21:0]          mdiff;
    logic signed [MW:0]   s_w;
    logic [3:0]           band_next;
    logic                 paint_next;
    pow_t                 tgt_next;
    logic                 sel4_next;
    pow_t                 k0_next;
    logic                 neg_next;

    always_comb
    begin
        n_div     = lo1_reg ? 13'(x1_reg >> 7) : 13'(x1_reg >> 6);
        recip     = lo1_reg ? 14'd6554 : 14'd11651;
        prod      = 27'(n_div) * 27'(recip);
        gray_next = lo1_reg ? 8'(prod >> 15) : 8'(prod >> 19);

        sneg   = s1_reg[SW-1];
        smag   = sneg ? $unsigned(-s1_reg) : $unsigned(s1_reg);
        smag_w = MW'(smag);
        mdiff  = (smag_w > MW'(DIFF_FULL)) ? 22'(DIFF_FULL) : smag_w[21:0];

        s_w       = (MW+1)'(s1_reg);
        band_next = 4'd0;
        for (int i = 0; i < NUM_LIMITS; i++)
        begin
            if (s_w >= $signed((MW+1)'(band_threshold(4'(i)))))
            begin
                band_next = band_next + 4'd1;
            end
        end
        paint_next = (s_w > $signed((MW+1)'(PAINT_MIN)));

        if (mode1_reg == MODE_WIND)
        begin
            tgt_next  = PW'(w1_reg) << WIND_SHIFT;
            sel4_next = 1'b0;
            k0_next   = PW'(WIND_DEN);
            neg_next  = wneg1_reg;
        end
        else
        begin
            tgt_next  = PW'(mdiff) << DIFF_SHIFT;
            sel4_next = 1'b1;
            k0_next   = PW'(DIFF_FULL);
            neg_next  = sneg;
        end
    end

    logic                 v2_reg;
    side_t                side2_reg;
    pow_t                 tgt2_reg;
    logic                 sel42_reg;
    pow_t                 k02_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side2_reg.mode  <= mode1_reg;
        side2_reg.skip  <= skip1_reg;
        side2_reg.neg   <= neg_next;
        side2_reg.paint <= paint_next;
        side2_reg.band  <= band_next;
        side2_reg.gray  <= gray_next;
        side2_reg.dark  <= 8'd0;
        tgt2_reg        <= tgt_next;
        sel42_reg       <= sel4_next;
        k02_reg         <= k0_next;
    end

    // stage 3: darkening, 0.4 in band mode, 0.2 otherwise
    logic [7:0] dark_next;
    side_t      side3_next;

    always_comb
    begin
        if (side2_reg.mode == MODE_BANDS)
        begin
            dark_next = 8'((16'(side2_reg.gray) * 16'd102) >> 8);
        end
        else
        begin
            dark_next = 8'((16'(side2_reg.gray) * 16'd51) >> 8);
        end
        side3_next      = side2_reg;
        side3_next.dark = dark_next;
    end

    logic  v3_reg;
    side_t side3_reg;
    pow_t  tgt3_reg;
    logic  sel43_reg;
    pow_t  k03_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side3_next;
        tgt3_reg  <= tgt2_reg;
        sel43_reg <= sel42_reg;
        k03_reg   <= k02_reg;
    end

    assign out_valid  = v3_reg;
    assign out_side   = side3_reg;
    assign out_target = tgt3_reg;
    assign out_sel4   = sel43_reg;
    assign out_k0     = k03_reg;

endmodule

`default_nettype wire

/* rtl/fcwp_root.sv */
// Pipelined root extraction, one result bit per stage: largest a with a^2*K <= target
// (wind) or a^4*K <= target (precipitation difference). Depends on fcwp_pkg.
`default_nettype none

module fcwp_root
    import fcwp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire side_t in_side,
    input  wire pow_t  in_target,
    input  wire logic  in_sel4,
    input  wire pow_t  in_k0,
    output logic       out_valid,
    output side_t      out_side,
    output logic [8:0] out_value
);

    // p_k holds a^k * K for the partial root a
    typedef struct packed {
        logic        sel4;
        pow_t        tgt;
        pow_t        p0;
        pow_t        p1;
        pow_t        p2;
        pow_t        p3;
        pow_t        p4;
        logic [8:0]  root;
        side_t       side;
    } rstage_t;

    rstage_t               cur   [0:ROOT_STEPS-1];
    logic [ROOT_STEPS-1:0] cur_v;
    rstage_t               st_reg [0:ROOT_STEPS-1];
    logic [ROOT_STEPS-1:0] v_reg;

    for (genvar s = 0; s < ROOT_STEPS; s++)
    begin : g_step
        localparam int SH = ROOT_STEPS - 1 - s;

        pow_t    t1, t2, t3, t4, h3, q3, q4;
        logic    take;
        rstage_t st_next;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                cur[s]      = '0;
                cur[s].sel4 = in_sel4;
                cur[s].tgt  = in_target;
                cur[s].p0   = in_k0;
                cur[s].side = in_side;
                cur_v[s]    = in_valid;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                cur[s]   = st_reg[s-1];
                cur_v[s] = v_reg[s-1];
            end
        end

        always_comb
        begin
            h3 = cur[s].p2 << SH;
            q3 = cur[s].p1 << (2 * SH);
            q4 = cur[s].p2 << (2 * SH);
            t1 = cur[s].p1 + (cur[s].p0 << SH);
            t2 = cur[s].p2 + (cur[s].p1 << (SH + 1)) + (cur[s].p0 << (2 * SH));
            t3 = cur[s].p3 + (h3 << 1) + h3 + (q3 << 1) + q3 + (cur[s].p0 << (3 * SH));
            t4 = cur[s].p4 + (cur[s].p3 << (SH + 2)) + (q4 << 2) + (q4 << 1)
               + (cur[s].p1 << (3 * SH + 2)) + (cur[s].p0 << (4 * SH));
            take = cur[s].sel4 ? (t4 <= cur[s].tgt) : (t2 <= cur[s].tgt);

            st_next = cur[s];
            if (take)
            begin
                st_next.root = cur[s].root | (9'd1 << SH);
                st_next.p1   = t1;
                st_next.p2   = t2;
                st_next.p3   = t3;
                st_next.p4   = t4;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= cur_v[s];
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[s] <= st_next;
        end
    end

    assign out_valid = v_reg[ROOT_STEPS-1];
    assign out_side  = st_reg[ROOT_STEPS-1].side;
    assign out_value = st_reg[ROOT_STEPS-1].root;

endmodule

`default_nettype wire

/* rtl/fcwp_color.sv */
// Tint and blend: builds the tint color and alpha, then blends with the darkened gray
// and picks the final pixel. Two register stages; depends on fcwp_pkg.
`default_nettype none

module fcwp_color
    import fcwp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire side_t      in_side,
    input  wire logic [8:0] in_root,
    output logic            out_valid,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue
);

    // stage 1: tint
    logic [7:0]  k_r, k_g, k_b;
    logic [23:0] bc;
    logic [8:0]  alpha_next;
    logic [7:0]  c_r_next, c_g_next, c_b_next;

    always_comb
    begin
        unique case (in_side.mode)
            MODE_WIND:
            begin
                k_r = in_side.neg ? 8'd64  : 8'd255;
                k_g = in_side.neg ? 8'd128 : 8'd64;
                k_b = in_side.neg ? 8'd255 : 8'd64;
            end
            MODE_DIFF:
            begin
                k_r = in_side.neg ? 8'd255 : 8'd0;
                k_g = in_side.neg ? 8'd64  : 8'd255;
                k_b = in_side.neg ? 8'd0   : 8'd255;
            end
            default:
            begin
                k_r = 8'd0;
                k_g = 8'd0;
                k_b = 8'd0;
            end
        endcase
        bc = band_color(in_side.band);
        if (in_side.mode == MODE_BANDS)
        begin
            alpha_next = band_alpha(in_side.band);
            c_r_next   = bc[23:16];
            c_g_next   = bc[15:8];
            c_b_next   = bc[7:0];
        end
        else
        begin
            alpha_next = in_root;
            c_r_next   = 8'((17'(k_r) * 17'(in_root)) >> 8);
            c_g_next   = 8'((17'(k_g) * 17'(in_root)) >> 8);
            c_b_next   = 8'((17'(k_b) * 17'(in_root)) >> 8);
        end
    end

    logic       v1_reg;
    side_t      side1_reg;
    logic [8:0] alpha1_reg;
    logic [7:0] c_r1_reg, c_g1_reg, c_b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg  <= in_side;
        alpha1_reg <= alpha_next;
        c_r1_reg   <= c_r_next;
        c_g1_reg   <= c_g_next;
        c_b1_reg   <= c_b_next;
    end

    // stage 2: blend and select
    logic [8:0]  inv_alpha;
    logic [16:0] sum_r, sum_g, sum_b;
    logic [7:0]  red_next, green_next, blue_next;

    always_comb
    begin
        inv_alpha = 9'd256 - alpha1_reg;
        sum_r = 17'(alpha1_reg) * 17'(c_r1_reg) + 17'(inv_alpha) * 17'(side1_reg.dark);
        sum_g = 17'(alpha1_reg) * 17'(c_g1_reg) + 17'(inv_alpha) * 17'(side1_reg.dark);
        sum_b = 17'(alpha1_reg) * 17'(c_b1_reg) + 17'(inv_alpha) * 17'(side1_reg.dark);
        priority if (side1_reg.mode == MODE_FLUX || side1_reg.skip)
        begin
            red_next   = side1_reg.gray;
            green_next = side1_reg.gray;
            blue_next  = side1_reg.gray;
        end
        else if (side1_reg.mode == MODE_BANDS && !side1_reg.paint)
        begin
            red_next   = side1_reg.dark;
            green_next = side1_reg.dark;
            blue_next  = side1_reg.dark;
        end
        else
        begin
            red_next   = 8'(sum_r >> 8);
            green_next = 8'(sum_g >> 8);
            blue_next  = 8'(sum_b >> 8);
        end
    end

    logic       done_reg;
    logic [7:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign out_valid = done_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

/* rtl/false_color_weather_pixel.sv */
// False-color weather pixel, top level. Each pixel goes through front, root and color.
// Throughput: one pixel per clock; busy is never raised, the pipeline always advances.
// The 9-stage root pipeline (one root bit per stage) is the longest of the three.
// Reset (rst_n low, asynchronous): all stage valid bits clear, plot_mode returns to 0.
// done is a one-cycle strobe; the receiver cannot stall, so results are never held.
// Depends on fcwp_pkg, fcwp_front, fcwp_root, fcwp_color.
`default_nettype none

module false_color_weather_pixel
    import fcwp_pkg::*;
#(
    parameter int OVERLAY_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [15:0]                    flux_value,
    input  wire logic signed [OVERLAY_BITS-1:0] overlay_left,
    input  wire logic signed [OVERLAY_BITS-1:0] overlay_center,
    input  wire logic signed [OVERLAY_BITS-1:0] overlay_right,
    input  wire logic                           edge_pixel,
    // configuration write channel (plot_mode)
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_data,
    // result
    output logic                                done,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue
);

    localparam int LATENCY = 3 + ROOT_STEPS + 2;

    // Mode register; the user must write it only between frames, the block itself
    // does not enforce this. Each beat samples it at entry and carries it with the pixel.
    mode_t plot_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plot_mode_reg <= MODE_FLUX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            plot_mode_reg <= mode_t'(cfg_data);
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic  accept;
    assign accept = start && !busy;

    // Front: gray level, smoothing, band search, root target (3 stages)
    logic  fr_valid;
    side_t fr_side;
    pow_t  fr_target;
    logic  fr_sel4;
    pow_t  fr_k0;

    fcwp_front #(
        .OVERLAY_BITS (OVERLAY_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .mode           (plot_mode_reg),
        .flux_value     (flux_value),
        .overlay_left   (overlay_left),
        .overlay_center (overlay_center),
        .overlay_right  (overlay_right),
        .edge_pixel     (edge_pixel),
        .out_valid      (fr_valid),
        .out_side       (fr_side),
        .out_target     (fr_target),
        .out_sel4       (fr_sel4),
        .out_k0         (fr_k0)
    );

    // Root: square root (wind) or fourth root (precip difference), 9 stages
    logic       rt_valid;
    side_t      rt_side;
    logic [8:0] rt_root;

    fcwp_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_target (fr_target),
        .in_sel4   (fr_sel4),
        .in_k0     (fr_k0),
        .out_valid (rt_valid),
        .out_side  (rt_side),
        .out_value (rt_root)
    );

    // Tint and blend, 2 stages, registered outputs
    fcwp_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_side   (rt_side),
        .in_root   (rt_root),
        .out_valid (done),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    // A result beat only ever comes from an accepted command beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done without matching start");

    // Alpha from the root pipeline never exceeds 1.0 in Q1.8.
    assert property (@(posedge clk) disable iff (!rst_n)
        rt_valid |-> (rt_root <= 9'd256))
        else $error("root alpha out of range");

    // Flux-mode and edge pixels come out as pure gray.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rt_valid && (rt_side.mode == MODE_FLUX || rt_side.skip))
            |=> ##1 (red == green && green == blue))
        else $error("gray pixel has color");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench for false_color_weather_pixel: directed and random pixels in all four plot modes.
// Scoreboard class predicts each pixel; depends on fcwp_pkg and the RTL top.
`default_nettype none

module tb;
    import fcwp_pkg::*;

    localparam int LATENCY = 14;

    // pixel color predictor and store of expected colors
    class pixel_scoreboard;
        logic [23:0] expected_q[$];
        int          errors;
        mode_t       mode;

        function new();
            errors = 0;
            mode = MODE_FLUX;
        endfunction

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function int unsigned mix(int unsigned a, int unsigned c, int unsigned d);
            return (a * c + (256 - a) * d) >> 8;
        endfunction

        function int unsigned gray_of(logic [15:0] raw);
            int unsigned f;
            f = 32'(raw);
            if (f < 1280) f = 1280;
            if (f > 4800) f = 4800;
            if (f < 1920) return (114240 + 51 * (1920 - f)) / 640;
            return (367200 + 51 * (4800 - f)) / 2880;
        endfunction

        function logic [23:0] color_of(logic [15:0] flux, logic signed [31:0] l,
                                       logic signed [31:0] c, logic signed [31:0] r,
                                       logic edge_in);
            int unsigned g, d, a, k;
            int unsigned rr, gg, bb;
            longint s, u;
            longint unsigned m;
            logic [23:0] bc;
            g = gray_of(flux);
            rr = g; gg = g; bb = g;
            if (mode != MODE_FLUX && !edge_in)
            begin
                d = (mode == MODE_BANDS) ? ((g * 102) >> 8) : ((g * 51) >> 8);
                rr = d; gg = d; bb = d;
                if (mode == MODE_WIND)
                begin
                    u = c;
                    m = (u < 0) ? -u : u;
                    if (m > 2560) m = 2560;
                    a = 32'(isqrt(m * 128 / 5));
                    if (u < 0)
                    begin
                        rr = mix(a, (64 * a) >> 8, d);
                        gg = mix(a, (128 * a) >> 8, d);
                        bb = mix(a, (255 * a) >> 8, d);
                    end
                    else
                    begin
                        rr = mix(a, (255 * a) >> 8, d);
                        gg = mix(a, (64 * a) >> 8, d);
                        bb = mix(a, (64 * a) >> 8, d);
                    end
                end
                else
                begin
                    s = longint'(l) + 3 * longint'(c) + longint'(r);
                    if (mode == MODE_BANDS)
                    begin
                        if (s * 24 > 13890)
                        begin
                            k = 0;
                            while (k < 13 && s >= longint'(band_threshold(4'(k))))
                                k++;
                            bc = band_color(4'(k));
                            a = 32'(band_alpha(4'(k)));
                            rr = mix(a, 32'(bc[23:16]), d);
                            gg = mix(a, 32'(bc[15:8]), d);
                            bb = mix(a, 32'(bc[7:0]), d);
                        end
                    end
                    else
                    begin
                        m = (s < 0) ? -s : s;
                        if (m > 2500200) m = 2500200;
                        a = 32'(isqrt(isqrt((m << 32) / 2500200)));
                        if (s < 0)
                        begin
                            rr = mix(a, (255 * a) >> 8, d);
                            gg = mix(a, (64 * a) >> 8, d);
                            bb = mix(a, 0, d);
                        end
                        else
                        begin
                            rr = mix(a, 0, d);
                            gg = mix(a, (255 * a) >> 8, d);
                            bb = mix(a, (255 * a) >> 8, d);
                        end
                    end
                end
            end
            return {rr[7:0], gg[7:0], bb[7:0]};
        endfunction

        function void note_pixel(logic [15:0] flux, logic signed [31:0] l,
                                 logic signed [31:0] c, logic signed [31:0] r, logic e);
            expected_q.insert(expected_q.size(), color_of(flux, l, c, r, e));
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            logic [23:0] want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel %0d %0d %0d", r, g, b);
                return;
            end
            want = expected_q.pop_front();
            if (want !== {r, g, b})
            begin
                errors++;
                if (errors <= 10)
                    $display("pixel mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                             want[23:16], want[15:8], want[7:0], r, g, b);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        flux_value;
    logic signed [31:0] overlay_left;
    logic signed [31:0] overlay_center;
    logic signed [31:0] overlay_right;
    logic               edge_pixel;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_data;
    logic               done;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    pixel_scoreboard sb;
    bit              calm;   // no idle bursts near the end

    false_color_weather_pixel #(.OVERLAY_BITS(32)) DUT (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .flux_value(flux_value), .overlay_left(overlay_left),
        .overlay_center(overlay_center), .overlay_right(overlay_right),
        .edge_pixel(edge_pixel),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .red(red), .green(green), .blue(blue)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // results are sampled at the rising edge
    always @(posedge clk)
        if (rst_n && done)
            sb.check_pixel(red, green, blue);

    // one pixel beat; start stays high across back-to-back beats
    task automatic send_pixel(logic [15:0] f, logic signed [31:0] l, logic signed [31:0] c,
                              logic signed [31:0] r, logic e);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            start <= 0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
        end
        start <= 1;
        flux_value <= f;
        overlay_left <= l;
        overlay_center <= c;
        overlay_right <= r;
        edge_pixel <= e;
        // busy only moves at the rising edge, so its low-phase value is what the edge sees
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_pixel(f, l, c, r, e);
        @(negedge clk);
    endtask

    // mode write only while idle: drain expectations, then wait out the pipeline
    task automatic write_mode(mode_t m);
        start <= 0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
        cfg_valid <= 1;
        cfg_data <= m;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        sb.mode = m;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // overlay values biased toward the interesting thresholds
    function automatic logic signed [31:0] rand_overlay(mode_t m);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 6000)) - 3000;
            2: return $signed($urandom_range(0, 1200000)) - 600000;
            3: return $signed($urandom_range(0, 800000));
            default: return (m == MODE_WIND) ? $signed($urandom_range(0, 6000)) - 3000
                                             : $signed($urandom_range(0, 500000)) - 100000;
        endcase
    endfunction

    initial
    begin
        mode_t m;
        logic [15:0] f;
        rst_n = 0;
        start = 0;
        flux_value = 0;
        overlay_left = 0;
        overlay_center = 0;
        overlay_right = 0;
        edge_pixel = 0;
        cfg_valid = 0;
        cfg_data = 0;
        calm = 0;
        sb = new();
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: flux extremes in reset mode, then each mode's corners
        send_pixel(16'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_pixel(16'hffff, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
        send_pixel(16'd1919, 32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_pixel(16'd1920, 32'sd0, 32'sd0, 32'sd0, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            write_mode(mode_t'(i));
            send_pixel(16'd3000, 32'sd0, 32'sd0, 32'sd0, 1'b0);    // zero difference
            send_pixel(16'd3000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
            send_pixel(16'd3000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
            send_pixel(16'd3000, 32'sd1000, 32'sd9000000, -32'sd5, 1'b1);  // edge pixel
            send_pixel(16'd2000, 32'sd0, 32'sd116, 32'sd230, 1'b0);  // low rate threshold
            send_pixel(16'd2000, 32'sd100, -32'sd2560, 32'sd4, 1'b0);
        end

        // random phases over all modes, extremes included
        for (int p = 0; p < 12; p++)
        begin
            m = (p < 4) ? mode_t'(p) : mode_t'($urandom_range(0, 3));
            write_mode(m);
            if (p == 11)
                calm = 1;
            for (int i = 0; i < 150; i++)
            begin
                f = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1100, 5000));
                send_pixel(f, rand_overlay(m), rand_overlay(m), rand_overlay(m),
                           $urandom_range(0, 7) == 0);
            end
        end

        start <= 0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
